>>> rtl/core/ptlru_pkg.sv
package ptlru_pkg;

   localparam int VIRTUAL_PAGES   = 64;
   localparam int PAGE_W          = $clog2(VIRTUAL_PAGES);
   localparam int PHYSICAL_FRAMES = 16;
   localparam int FRAME_W         = $clog2(PHYSICAL_FRAMES);
   localparam int FUSED_W         = $clog2(PHYSICAL_FRAMES + 1);
   localparam int OFFSET_MAX_BITS = 12;
   localparam int OFFSET_W        = 12;
   localparam int ADDR_W          = 16;
   localparam int TS_W            = 32;
   localparam int LIMIT_W         = 5;
   localparam int OWIDTH_W        = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int LIMIT_RESET     = 16;
   localparam int OWIDTH_RESET    = 8;

   typedef enum logic [0:0] {
      REG_FRAME_LIMIT  = 1'b0,
      REG_OFFSET_WIDTH = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SCAN,
      ST_EVICT
   } state_type;

   // effective configuration, already saturated
   typedef struct packed {
      logic [FUSED_W-1:0]  limit;
      logic [OWIDTH_W-1:0] owidth;
   } cfg_type;

   // one candidate frame presented to the lru compare unit
   typedef struct packed {
      logic               clear;
      logic               valid;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  owner;
      logic               owner_valid;
   } cand_type;

   typedef struct packed {
      logic               found;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  owner;
   } victim_type;

endpackage

>>> rtl/core/ptlru_csr.sv
module ptlru_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ptlru_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ptlru_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ptlru_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready,
   output ptlru_pkg::cfg_type                    cfg
);

   logic [ptlru_pkg::LIMIT_W-1:0]  frame_limit_ff, frame_limit_in;
   logic [ptlru_pkg::OWIDTH_W-1:0] offset_width_ff, offset_width_in;
   ptlru_pkg::reg_index_type       sel;
   logic                           wr_en;

   assign pready = 1'b1;
   assign sel    = ptlru_pkg::reg_index_type'(paddr[ptlru_pkg::CSR_ADDR_W-1]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      frame_limit_in  = frame_limit_ff;
      offset_width_in = offset_width_ff;
      if (wr_en) begin
         unique case (sel)
            ptlru_pkg::REG_FRAME_LIMIT: begin
               frame_limit_in = pwdata[ptlru_pkg::LIMIT_W-1:0];
            end
            ptlru_pkg::REG_OFFSET_WIDTH: begin
               offset_width_in = pwdata[ptlru_pkg::OWIDTH_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff  <= ptlru_pkg::LIMIT_W'(ptlru_pkg::LIMIT_RESET);
         offset_width_ff <= ptlru_pkg::OWIDTH_W'(ptlru_pkg::OWIDTH_RESET);
      end else begin
         frame_limit_ff  <= frame_limit_in;
         offset_width_ff <= offset_width_in;
      end
   end

   always_comb begin
      unique case (sel)
         ptlru_pkg::REG_FRAME_LIMIT: begin
            prdata = ptlru_pkg::CSR_DATA_W'(frame_limit_ff);
         end
         ptlru_pkg::REG_OFFSET_WIDTH: begin
            prdata = ptlru_pkg::CSR_DATA_W'(offset_width_ff);
         end
      endcase
   end

   // saturate to the usable ranges
   always_comb begin
      if (frame_limit_ff == '0) begin
         cfg.limit = ptlru_pkg::FUSED_W'(1);
      end else if (frame_limit_ff > ptlru_pkg::LIMIT_W'(ptlru_pkg::PHYSICAL_FRAMES)) begin
         cfg.limit = ptlru_pkg::FUSED_W'(ptlru_pkg::PHYSICAL_FRAMES);
      end else begin
         cfg.limit = ptlru_pkg::FUSED_W'(frame_limit_ff);
      end
      if (offset_width_ff > ptlru_pkg::OWIDTH_W'(ptlru_pkg::OFFSET_MAX_BITS)) begin
         cfg.owidth = ptlru_pkg::OWIDTH_W'(ptlru_pkg::OFFSET_MAX_BITS);
      end else begin
         cfg.owidth = offset_width_ff;
      end
   end

endmodule

>>> rtl/core/ptlru_victim.sv
module ptlru_victim (
   input  logic                              clock,
   input  logic                              reset,
   input  ptlru_pkg::cand_type               cand,
   input  logic [ptlru_pkg::TS_W-1:0]        cand_time,
   output ptlru_pkg::victim_type             victim
);

   logic                             found_ff, found_in;
   logic [ptlru_pkg::FRAME_W-1:0]    best_frame_ff, best_frame_in;
   logic [ptlru_pkg::PAGE_W-1:0]     best_owner_ff, best_owner_in;
   logic [ptlru_pkg::TS_W-1:0]       best_time_ff, best_time_in;
   logic                             take;

   // strict less-than keeps the lowest frame on equal times
   assign take = cand.valid && cand.owner_valid && (!found_ff || (cand_time < best_time_ff));

   always_comb begin
      found_in      = found_ff;
      best_frame_in = best_frame_ff;
      best_owner_in = best_owner_ff;
      best_time_in  = best_time_ff;
      if (cand.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in      = 1'b1;
         best_frame_in = cand.frame;
         best_owner_in = cand.owner;
         best_time_in  = cand_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_frame_ff <= best_frame_in;
      best_owner_ff <= best_owner_in;
      best_time_ff  <= best_time_in;
   end

   assign victim.found = found_ff;
   assign victim.frame = best_frame_ff;
   assign victim.owner = best_owner_ff;

endmodule

>>> rtl/core/page_table_lru_translate.sv
// Page table with lru replacement. A request is taken when start is high and busy is low;
// one result follows on the rsp_ ports, marked by rsp_valid for a single cycle, and cannot
// be held off. A hit, or a fault while a free frame remains, passes through the lookup and
// decide states and then strobes its result. A fault with every allowed frame in use
// walks the frames in use through one shared compare unit, one frame per cycle over the
// frame owner and last-use memories, before the evict state. The result is strobed in the
// first cycle that busy is low again, so a new request may be given in that cycle. The
// user must write configuration through the psel/penable port only while busy is low and
// no result is pending; the block itself does not enforce it.
module page_table_lru_translate (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ptlru_pkg::PAGE_W-1:0]          req_page_number,
   input  logic                                  req_write_access,
   input  logic [ptlru_pkg::OFFSET_W-1:0]        req_offset,
   input  logic [ptlru_pkg::TS_W-1:0]            req_timestamp,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic [ptlru_pkg::FRAME_W-1:0]         rsp_frame,
   output logic [ptlru_pkg::ADDR_W-1:0]          rsp_phys_addr,
   output logic                                  rsp_evicted,
   output logic                                  rsp_victim_dirty,
   output logic [ptlru_pkg::PAGE_W-1:0]          rsp_victim_page,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ptlru_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ptlru_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ptlru_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);

   localparam int PAGES  = ptlru_pkg::VIRTUAL_PAGES;
   localparam int FRAMES = ptlru_pkg::PHYSICAL_FRAMES;
   localparam int PW     = ptlru_pkg::PAGE_W;
   localparam int FW     = ptlru_pkg::FRAME_W;
   localparam int UW     = ptlru_pkg::FUSED_W;
   localparam int AW     = ptlru_pkg::ADDR_W;
   localparam int TW     = ptlru_pkg::TS_W;

   ptlru_pkg::cfg_type    cfg;
   ptlru_pkg::state_type  state_ff, state_in;
   ptlru_pkg::cand_type   cand;
   ptlru_pkg::victim_type victim;

   // request registers
   logic [PW-1:0]                 page_ff;
   logic                          wr_ff;
   logic [ptlru_pkg::OFFSET_W-1:0] off_ff;
   logic [TW-1:0]                 ts_ff;
   logic                          accept;

   // page state
   logic [PAGES-1:0] valid_ff, valid_in;
   logic [PAGES-1:0] dirty_ff, dirty_in;
   logic [UW-1:0]    frames_used_ff, frames_used_in;

   // memories
   logic [FW-1:0] pf_mem [PAGES];
   logic [TW-1:0] lu_mem [PAGES];
   logic [PW-1:0] fo_mem [FRAMES];
   logic [FW-1:0] pf_rdata_ff;
   logic [TW-1:0] lu_rdata_ff;
   logic [PW-1:0] fo_rdata_ff;

   // scan pipeline
   logic [UW-1:0] scan_idx_ff, scan_idx_in;
   logic          s1_vld_ff;
   logic [FW-1:0] s1_idx_ff;
   logic          s2_vld_ff;
   logic [FW-1:0] s2_idx_ff;
   logic [PW-1:0] s2_owner_ff;
   logic          s2_ovalid_ff;

   // decisions
   logic          hit_now, alloc_now, evict_now, finish_now;
   logic          issue, scan_done, go_scan;
   logic [FW-1:0] res_frame;
   logic [AW-1:0] addr_mask, res_addr;

   // result registers
   logic          rsp_valid_ff;
   logic          rsp_hit_ff;
   logic [FW-1:0] rsp_frame_ff;
   logic [AW-1:0] rsp_phys_addr_ff;
   logic          rsp_evicted_ff;
   logic          rsp_victim_dirty_ff;
   logic [PW-1:0] rsp_victim_page_ff;

   ptlru_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ptlru_victim u_victim (
      .clock     (clock),
      .reset     (reset),
      .cand      (cand),
      .cand_time (lu_rdata_ff),
      .victim    (victim)
   );

   assign busy   = (state_ff != ptlru_pkg::ST_IDLE);
   assign accept = start && !busy;

   // fsm outputs
   always_comb begin
      hit_now   = 1'b0;
      alloc_now = 1'b0;
      evict_now = 1'b0;
      go_scan   = 1'b0;
      issue     = 1'b0;
      scan_done = 1'b0;
      unique case (state_ff)
         ptlru_pkg::ST_DECIDE: begin
            if (valid_ff[page_ff]) begin
               hit_now = 1'b1;
            end else if (frames_used_ff < cfg.limit) begin
               alloc_now = 1'b1;
            end else begin
               go_scan = 1'b1;
            end
         end
         ptlru_pkg::ST_SCAN: begin
            issue     = (scan_idx_ff < frames_used_ff);
            scan_done = !issue && !s1_vld_ff;
         end
         ptlru_pkg::ST_EVICT: begin
            evict_now = 1'b1;
         end
         ptlru_pkg::ST_IDLE, ptlru_pkg::ST_LOOKUP: begin
         end
         default: begin
         end
      endcase
      finish_now = hit_now || alloc_now || evict_now;
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptlru_pkg::ST_IDLE: begin
            if (accept) state_in = ptlru_pkg::ST_LOOKUP;
         end
         ptlru_pkg::ST_LOOKUP: begin
            state_in = ptlru_pkg::ST_DECIDE;
         end
         ptlru_pkg::ST_DECIDE: begin
            state_in = go_scan ? ptlru_pkg::ST_SCAN : ptlru_pkg::ST_IDLE;
         end
         ptlru_pkg::ST_SCAN: begin
            if (scan_done) state_in = ptlru_pkg::ST_EVICT;
         end
         ptlru_pkg::ST_EVICT: begin
            state_in = ptlru_pkg::ST_IDLE;
         end
         default: begin
            state_in = ptlru_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptlru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page_number;
         wr_ff   <= req_write_access;
         off_ff  <= req_offset;
         ts_ff   <= req_timestamp;
      end
   end

   // frame chosen for this request
   always_comb begin
      priority if (hit_now) begin
         res_frame = pf_rdata_ff;
      end else if (alloc_now) begin
         res_frame = frames_used_ff[FW-1:0];
      end else if (victim.found) begin
         res_frame = victim.frame;
      end else begin
         res_frame = '0;
      end
   end

   assign addr_mask = (AW'(1) << cfg.owidth) - AW'(1);
   assign res_addr  = (AW'(res_frame) << cfg.owidth) | (AW'(off_ff) & addr_mask);

   // valid / dirty bits and frame count
   always_comb begin
      valid_in       = valid_ff;
      dirty_in       = dirty_ff;
      frames_used_in = frames_used_ff;
      if (hit_now && wr_ff) begin
         dirty_in[page_ff] = 1'b1;
      end
      if (evict_now && victim.found) begin
         valid_in[victim.owner] = 1'b0;
         dirty_in[victim.owner] = 1'b0;
      end
      if (alloc_now || evict_now) begin
         valid_in[page_ff] = 1'b1;
         dirty_in[page_ff] = wr_ff;
      end
      if (alloc_now) begin
         frames_used_in = frames_used_ff + UW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         dirty_ff       <= '0;
         frames_used_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         dirty_ff       <= dirty_in;
         frames_used_ff <= frames_used_in;
      end
   end

   // page frame memory
   always_ff @(posedge clock) begin
      if (alloc_now || evict_now) begin
         pf_mem[page_ff] <= res_frame;
      end
      pf_rdata_ff <= pf_mem[page_ff];
   end

   // last-use memory, read by owner during the scan
   always_ff @(posedge clock) begin
      if (finish_now) begin
         lu_mem[page_ff] <= ts_ff;
      end
      lu_rdata_ff <= lu_mem[fo_rdata_ff];
   end

   // frame owner memory, read by scan index
   always_ff @(posedge clock) begin
      if (alloc_now || evict_now) begin
         fo_mem[res_frame] <= page_ff;
      end
      fo_rdata_ff <= fo_mem[scan_idx_ff[FW-1:0]];
   end

   // scan sequencer: frame index -> owner -> last-use time -> compare
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (state_ff == ptlru_pkg::ST_DECIDE) begin
         scan_idx_in = '0;
      end else if (issue) begin
         scan_idx_in = scan_idx_ff + UW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         s1_vld_ff   <= issue;
         s2_vld_ff   <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= scan_idx_ff[FW-1:0];
      s2_idx_ff    <= s1_idx_ff;
      s2_owner_ff  <= fo_rdata_ff;
      s2_ovalid_ff <= valid_ff[fo_rdata_ff];
   end

   always_comb begin
      cand.clear       = (state_ff == ptlru_pkg::ST_DECIDE);
      cand.valid       = s2_vld_ff;
      cand.frame       = s2_idx_ff;
      cand.owner       = s2_owner_ff;
      cand.owner_valid = s2_ovalid_ff;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= finish_now;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_now) begin
         rsp_hit_ff       <= hit_now;
         rsp_frame_ff     <= res_frame;
         rsp_phys_addr_ff <= res_addr;
         if (evict_now && victim.found) begin
            rsp_evicted_ff      <= 1'b1;
            rsp_victim_dirty_ff <= dirty_ff[victim.owner];
            rsp_victim_page_ff  <= victim.owner;
         end else begin
            rsp_evicted_ff      <= 1'b0;
            rsp_victim_dirty_ff <= 1'b0;
            rsp_victim_page_ff  <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_phys_addr    = rsp_phys_addr_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_victim_dirty = rsp_victim_dirty_ff;
   assign rsp_victim_page  = rsp_victim_page_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not make the block busy");

   a_frames_bound: assert property (@(posedge clock) disable iff (reset)
      frames_used_ff <= UW'(FRAMES))
      else $error("frame count beyond frame store");

   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_hit || !rsp_evicted)) |->
         (!rsp_evicted && !rsp_victim_dirty && (rsp_victim_page == '0)))
      else $error("victim details without an eviction");

endmodule
